// ===== rtl/pip_pkg.sv =====
// Shared types and constants for the polygon point-inclusion block.
// Used by the edge unit and the top level; no dependencies.
`timescale 1ns / 1ps

package pip_pkg;

  // Item kinds carried on in_tuser
  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TEST  = 2'd2;

  localparam int DEF_MAX_VERTICES = 32;
  localparam int DEF_COORD_BITS   = 16;

  // Width of the vertex_total result field
  localparam int TOTAL_W = 6;

  // Fewer vertices than this never enclose a point
  localparam int MIN_POLY_VERTS = 3;

  typedef struct packed {
    logic clr;  // restart the crossing parity
    logic vld;  // an edge (current and previous vertex) is presented
  } edge_ctl_t;

  typedef struct packed {
    logic busy; // edges still in flight
    logic odd;  // crossing parity so far
  } edge_sts_t;

endpackage

// ===== rtl/polygon_point_inclusion.sv =====
// Polygon point-inclusion block: vertex table in one RAM, sequencer, box tracking.
// Flow: every accepted item moves from S_IDLE to S_DONE, where out_tvalid is registered;
// a test point with n >= 3 stored vertices passes S_SCAN first, the single RAM read port
// scanning one vertex per cycle into the three-stage edge pipeline behind it.
// One item in work at a time; a new item is
// taken while the previous result waits on out_tready. Reset: count and box go to zero.
`timescale 1ns / 1ps

module polygon_point_inclusion
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int COORD_BITS   = DEF_COORD_BITS,
  localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((4 * COORD_BITS + TOTAL_W + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,  // x_coord, y_coord
  input  logic [ACT_W-1:0] in_tuser,  // action
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata  // inside_res, box_min_x, box_min_y, box_max_x,
                                      // box_max_y, vertex_total, dropped
);

  localparam int CB    = COORD_BITS;
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int TW    = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           st_r, st_nxt;
  logic [ACT_W-1:0]     act_r;
  logic signed [CB-1:0] qx_r, qy_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic signed [CB-1:0] min_x_r, min_y_r, max_x_r, max_y_r;
  logic signed [CB-1:0] min_x_nxt, min_y_nxt, max_x_nxt, max_y_nxt;
  logic                 out_v_r, out_v_nxt;
  logic [OUT_W-1:0]     out_d_r, out_d_nxt;

  logic                 iss_first_r, iss_first_nxt;
  logic [AW-1:0]        iss_addr_r, iss_addr_nxt;
  logic [CNT_W-1:0]     iss_left_r, iss_left_nxt;
  logic                 rv_r, rfirst_r;
  logic signed [CB-1:0] prv_x_r, prv_y_r;

  logic                 accept, out_free, fire, rd_issue, scan_done, full, enough;
  logic                 in_poly, dropped, we;
  logic [2*CB-1:0]      rdata;
  logic signed [CB-1:0] cur_x, cur_y;
  logic [TW-1:0]        cnt_ext;
  edge_ctl_t            e_ctl;
  edge_sts_t            e_sts;

  assign in_tready = (st_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_v_r || out_tready;
  assign fire      = (st_r == S_DONE) && out_free;
  assign full      = (cnt_r == CNT_W'(MAX_VERTICES));
  assign enough    = (cnt_r >= CNT_W'(MIN_POLY_VERTS));
  assign rd_issue  = (st_r == S_SCAN) && (iss_first_r || (iss_left_r != '0));
  assign scan_done = (st_r == S_SCAN) && !iss_first_r && (iss_left_r == '0)
                     && !rv_r && !e_sts.busy;
  assign we        = fire && (act_r == ACT_ADD) && !full;

  assign cur_x = rdata[CB-1:0];
  assign cur_y = rdata[2*CB-1:CB];

  assign e_ctl.clr = accept;
  assign e_ctl.vld = rv_r && !rfirst_r;

  pip_ram #(
    .WIDTH(2 * CB),
    .DEPTH(MAX_VERTICES),
    .AW   (AW)
  ) u_vtx_ram (
    .clk  (clk),
    .we   (we),
    .waddr(cnt_r[AW-1:0]),
    .wdata({qy_r, qx_r}),
    .raddr(iss_addr_r),
    .rdata(rdata)
  );

  pip_edge #(
    .COORD_BITS(CB)
  ) u_edge (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (e_ctl),
    .qx   (qx_r),
    .qy   (qy_r),
    .cur_x(cur_x),
    .cur_y(cur_y),
    .prv_x(prv_x_r),
    .prv_y(prv_y_r),
    .sts  (e_sts)
  );

  // Sequencer and read issue
  always_comb begin
    st_nxt        = st_r;
    iss_first_nxt = iss_first_r;
    iss_addr_nxt  = iss_addr_r;
    iss_left_nxt  = iss_left_r;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          // read the last vertex first so it pairs with vertex zero
          iss_first_nxt = 1'b1;
          iss_addr_nxt  = AW'(cnt_r - 1'b1);
          iss_left_nxt  = cnt_r;
          st_nxt = ((in_tuser == ACT_TEST) && enough) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (iss_first_r) begin
          iss_first_nxt = 1'b0;
          iss_addr_nxt  = '0;
        end else if (iss_left_r != '0) begin
          iss_addr_nxt = iss_addr_r + 1'b1;
          iss_left_nxt = iss_left_r - 1'b1;
        end
        if (scan_done) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // State update and result build
  always_comb begin
    cnt_nxt   = cnt_r;
    min_x_nxt = min_x_r;
    min_y_nxt = min_y_r;
    max_x_nxt = max_x_r;
    max_y_nxt = max_y_r;
    in_poly   = 1'b0;
    dropped   = 1'b0;
    unique case (act_r)
      ACT_CLEAR: begin
        cnt_nxt   = '0;
        min_x_nxt = '0;
        min_y_nxt = '0;
        max_x_nxt = '0;
        max_y_nxt = '0;
      end
      ACT_ADD: begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == '0) begin
            min_x_nxt = qx_r;
            max_x_nxt = qx_r;
            min_y_nxt = qy_r;
            max_y_nxt = qy_r;
          end else begin
            if (qx_r < min_x_r) min_x_nxt = qx_r;
            if (qy_r < min_y_r) min_y_nxt = qy_r;
            if (qx_r > max_x_r) max_x_nxt = qx_r;
            if (qy_r > max_y_r) max_y_nxt = qy_r;
          end
        end
      end
      ACT_TEST: begin
        in_poly = enough && e_sts.odd;
      end
      default: begin
      end
    endcase
    cnt_ext   = TW'(cnt_nxt);
    out_d_nxt = OUT_W'({dropped, cnt_ext[TOTAL_W-1:0], max_y_nxt, max_x_nxt,
                        min_y_nxt, min_x_nxt, in_poly});
    out_v_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      min_x_r     <= '0;
      min_y_r     <= '0;
      max_x_r     <= '0;
      max_y_r     <= '0;
      out_v_r     <= 1'b0;
      iss_first_r <= 1'b0;
      iss_left_r  <= '0;
      rv_r        <= 1'b0;
      rfirst_r    <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_v_r     <= out_v_nxt;
      iss_first_r <= iss_first_nxt;
      iss_left_r  <= iss_left_nxt;
      rv_r        <= rd_issue;
      rfirst_r    <= rd_issue && iss_first_r;
      if (fire) begin
        cnt_r   <= cnt_nxt;
        min_x_r <= min_x_nxt;
        min_y_r <= min_y_nxt;
        max_x_r <= max_x_nxt;
        max_y_r <= max_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_addr_r <= iss_addr_nxt;
    if (accept) begin
      act_r <= in_tuser;
      qx_r  <= in_tdata[CB-1:0];
      qy_r  <= in_tdata[2*CB-1:CB];
    end
    // hold the previous vertex for the next edge
    if (rv_r) begin
      prv_x_r <= cur_x;
      prv_y_r <= cur_y;
    end
    if (fire) begin
      out_d_r <= out_d_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

// ===== rtl/pip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pip_edge.sv =====
// Edge crossing unit: three-stage pipeline (differences, products, parity).
// Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_edge
  import pip_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  edge_ctl_t                    ctl,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  input  logic signed [COORD_BITS-1:0] cur_x,
  input  logic signed [COORD_BITS-1:0] cur_y,
  input  logic signed [COORD_BITS-1:0] prv_x,
  input  logic signed [COORD_BITS-1:0] prv_y,
  output edge_sts_t                    sts
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] a_raw, d_raw, a_c, b_c, c_c, d_c;
  logic                 cross_c;

  logic                 s1_v_r, s2_v_r, odd_r;
  logic                 s1_v_nxt, s2_v_nxt, odd_nxt;
  logic signed [DW-1:0] a_r, b_r, c_r, d_r;
  logic                 cross1_r, cross2_r;
  logic signed [PW-1:0] p1_r, p2_r;

  always_comb begin
    a_raw = DW'(qy) - DW'(cur_y);
    d_raw = DW'(prv_y) - DW'(cur_y);
    b_c   = DW'(prv_x) - DW'(cur_x);
    c_c   = DW'(qx) - DW'(cur_x);
    // flip both sides when the edge runs downward
    a_c   = d_raw[DW-1] ? -a_raw : a_raw;
    d_c   = d_raw[DW-1] ? -d_raw : d_raw;
    cross_c = ((cur_y < qy) && (prv_y >= qy)) || ((prv_y < qy) && (cur_y >= qy));
  end

  always_comb begin
    s1_v_nxt = ctl.vld && !ctl.clr;
    s2_v_nxt = s1_v_r && !ctl.clr;
    odd_nxt  = odd_r;
    if (ctl.clr) begin
      odd_nxt = 1'b0;
    end else if (s2_v_r && cross2_r && (p1_r < p2_r)) begin
      odd_nxt = !odd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      odd_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      odd_r  <= odd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_c;
    b_r      <= b_c;
    c_r      <= c_c;
    d_r      <= d_c;
    cross1_r <= cross_c;
    p1_r     <= a_r * b_r;
    p2_r     <= c_r * d_r;
    cross2_r <= cross1_r;
  end

  assign sts.busy = s1_v_r || s2_v_r;
  assign sts.odd  = odd_r;

endmodule
